### rtl/scrl_pkg.sv
// ----------------------------------------------------------------------------
// scrl_pkg
// Shared types, codes and helpers for the rate-limited steering controller.
// ----------------------------------------------------------------------------
package scrl_pkg;

  localparam int DATA_W            = 32;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int COEF_W            = 17;
  localparam int COEF_BITS         = 16;
  localparam int COEF_ONE          = 65536;
  localparam int LIMIT_W           = 31;
  localparam int MODE_W            = 3;
  localparam int DEG_SHIFT         = 32;
  localparam int DEG2RAD_Q32       = 74961321;
  localparam int MUL_A_W           = DATA_W + 1;
  localparam int MUL_B_W           = DATA_W;
  localparam int PROD_W            = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W         = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_LAT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_HEAD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE   = 3'd7;

  // control laws
  typedef logic [1:0] law_t;
  localparam law_t LAW_PP  = 2'd0;
  localparam law_t LAW_LQR = 2'd1;
  localparam law_t LAW_SMC = 2'd2;
  localparam law_t LAW_MPC = 2'd3;

  // multiplier operand pairs
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_LATF_COEF = 3'd0;
  localparam mul_sel_t MUL_PURF_COEF = 3'd1;
  localparam mul_sel_t MUL_HEAD_DEG  = 3'd2;
  localparam mul_sel_t MUL_GA_LAT    = 3'd3;
  localparam mul_sel_t MUL_GB_HR     = 3'd4;
  localparam mul_sel_t MUL_GC_PREV   = 3'd5;
  localparam mul_sel_t MUL_GB_LATF   = 3'd6;
  localparam mul_sel_t MUL_GA_PURF   = 3'd7;

  // accumulator and filter-state operations, most of them on the previous product
  typedef logic [2:0] acc_op_t;
  localparam acc_op_t ACC_NONE     = 3'd0;
  localparam acc_op_t ACC_UPD_LATF = 3'd1;
  localparam acc_op_t ACC_UPD_PURF = 3'd2;
  localparam acc_op_t ACC_HR       = 3'd3;
  localparam acc_op_t ACC_LOAD     = 3'd4;
  localparam acc_op_t ACC_ADD      = 3'd5;
  localparam acc_op_t ACC_ADD_HR   = 3'd6;
  localparam acc_op_t ACC_ADD_PREV = 3'd7;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     calc_target;
    logic     calc_diff;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    law_t law;
    logic slot_free;
  } status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = DATA_W'(hi);
    end else if (v < lo) begin
      sat32 = DATA_W'(lo);
    end else begin
      sat32 = DATA_W'(v);
    end
  endfunction

endpackage

### rtl/scrl_ctrl.sv
// ----------------------------------------------------------------------------
// scrl_ctrl
// Sequencer: steps the shared multiplier and accumulator through one law.
// ----------------------------------------------------------------------------
module scrl_ctrl
  import scrl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_S1     = 4'd1;
  localparam logic [3:0] ST_S2     = 4'd2;
  localparam logic [3:0] ST_S3     = 4'd3;
  localparam logic [3:0] ST_S4     = 4'd4;
  localparam logic [3:0] ST_S5     = 4'd5;
  localparam logic [3:0] ST_S6     = 4'd6;
  localparam logic [3:0] ST_TGT    = 4'd7;
  localparam logic [3:0] ST_DIFF   = 4'd8;
  localparam logic [3:0] ST_COMMIT = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_HEAD_DEG;
    cmd.acc_op = ACC_NONE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = ST_S1;
        end
      end
      ST_S1: begin
        cmd.mul_sel = (status.law == LAW_PP) ? MUL_LATF_COEF : MUL_HEAD_DEG;
        state_next  = ST_S2;
      end
      ST_S2: begin
        if (status.law == LAW_PP) begin
          cmd.mul_sel = MUL_PURF_COEF;
          cmd.acc_op  = ACC_UPD_LATF;
        end else begin
          cmd.mul_sel = MUL_GA_LAT;
          cmd.acc_op  = ACC_HR;
        end
        state_next = ST_S3;
      end
      ST_S3: begin
        unique case (status.law)
          LAW_PP: begin
            cmd.mul_sel = MUL_GB_LATF;
            cmd.acc_op  = ACC_UPD_PURF;
          end
          LAW_SMC: begin
            cmd.acc_op = ACC_LOAD;
          end
          default: begin
            cmd.mul_sel = MUL_GB_HR;
            cmd.acc_op  = ACC_LOAD;
          end
        endcase
        state_next = ST_S4;
      end
      ST_S4: begin
        unique case (status.law)
          LAW_PP: begin
            cmd.mul_sel = MUL_GA_PURF;
            cmd.acc_op  = ACC_LOAD;
            state_next  = ST_S5;
          end
          LAW_LQR: begin
            cmd.acc_op = ACC_ADD;
            state_next = ST_TGT;
          end
          LAW_SMC: begin
            cmd.acc_op = ACC_ADD_HR;
            state_next = ST_TGT;
          end
          default: begin
            cmd.mul_sel = MUL_GC_PREV;
            cmd.acc_op  = ACC_ADD;
            state_next  = ST_S5;
          end
        endcase
      end
      ST_S5: begin
        cmd.acc_op = ACC_ADD;
        state_next = (status.law == LAW_PP) ? ST_TGT : ST_S6;
      end
      ST_S6: begin
        cmd.acc_op = ACC_ADD_PREV;
        state_next = ST_TGT;
      end
      ST_TGT: begin
        cmd.calc_target = 1'b1;
        state_next      = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register is free
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/scrl_dp.sv
// ----------------------------------------------------------------------------
// scrl_dp
// Datapath: registers, shared multiplier, accumulator, limiter and output.
// ----------------------------------------------------------------------------
module scrl_dp
  import scrl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]           cfg_data,
  input  logic signed [DATA_W-1:0]    lateral_error,
  input  logic signed [DATA_W-1:0]    heading_error,
  input  logic signed [DATA_W-1:0]    pursuit_angle,
  input  logic signed [DATA_W-1:0]    previous_command,
  input  cmd_t                        cmd,
  output status_t                     status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [DATA_W-1:0]    target_angle,
  output logic signed [DATA_W-1:0]    steer_angle
);

  localparam int ACC_W = 2 * DATA_W + 3 - FRAC_BITS;
  localparam int FLT_W = DATA_W + 2;
  localparam int SUM_W = DATA_W + 3;
  localparam int LIM_W = DATA_W + 1;

  // configuration
  logic [MODE_W-1:0]         mode;
  logic signed [DATA_W-1:0]  gain_a;
  logic signed [DATA_W-1:0]  gain_b;
  logic signed [DATA_W-1:0]  gain_c;
  logic [COEF_W-1:0]         filter_lat;
  logic [COEF_W-1:0]         filter_head;
  logic [LIMIT_W-1:0]        max_step;
  logic [LIMIT_W-1:0]        max_angle;

  // state and working registers
  logic signed [DATA_W-1:0]  lat_filtered;
  logic signed [DATA_W-1:0]  pursuit_filtered;
  logic signed [DATA_W-1:0]  steer_current;
  logic signed [DATA_W-1:0]  lat_in;
  logic signed [DATA_W-1:0]  head_in;
  logic signed [DATA_W-1:0]  pursuit_in;
  logic signed [DATA_W-1:0]  prev_in;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MUL_A_W-1:0] head_rad;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DATA_W-1:0]  target;
  logic signed [DATA_W-1:0]  diff;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [COEF_W-1:0]         coef_lat_sat;
  logic [COEF_W-1:0]         coef_head_sat;
  logic signed [ACC_W-1:0]   prod_frac;
  logic signed [FLT_W-1:0]   prod_coef;
  logic signed [SUM_W-1:0]   flt_lat_sum;
  logic signed [SUM_W-1:0]   flt_pur_sum;
  logic signed [ACC_W-1:0]   delta;
  logic signed [ACC_W-1:0]   delta_signed;
  logic signed [LIM_W-1:0]   raw_diff;
  logic signed [LIM_W-1:0]   step_lim;
  logic signed [LIM_W-1:0]   raw_steer;
  logic signed [LIM_W-1:0]   angle_lim;
  logic signed [DATA_W-1:0]  steer_new;
  logic                      negate;

  assign status.law       = law_t'(mode[1:0]);
  assign status.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= '0;
      gain_a      <= '0;
      gain_b      <= '0;
      gain_c      <= '0;
      filter_lat  <= COEF_W'(16384);
      filter_head <= COEF_W'(21845);
      max_step    <= LIMIT_W'(65536);
      max_angle   <= LIMIT_W'(1966080);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MODE:        mode        <= cfg_data[MODE_W-1:0];
        REG_GAIN_A:      gain_a      <= cfg_data;
        REG_GAIN_B:      gain_b      <= cfg_data;
        REG_GAIN_C:      gain_c      <= cfg_data;
        REG_FILTER_LAT:  filter_lat  <= cfg_data[COEF_W-1:0];
        REG_FILTER_HEAD: filter_head <= cfg_data[COEF_W-1:0];
        REG_MAX_STEP:    max_step    <= cfg_data[LIMIT_W-1:0];
        REG_MAX_ANGLE:   max_angle   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // coefficients above one act as one
  assign coef_lat_sat  = (filter_lat > COEF_W'(COEF_ONE)) ? COEF_W'(COEF_ONE) : filter_lat;
  assign coef_head_sat = (filter_head > COEF_W'(COEF_ONE)) ? COEF_W'(COEF_ONE) : filter_head;

  always_comb begin
    case (cmd.mul_sel)
      MUL_LATF_COEF: begin
        mul_a = MUL_A_W'(lat_in) - MUL_A_W'(lat_filtered);
        mul_b = $signed({{(MUL_B_W-COEF_W){1'b0}}, coef_lat_sat});
      end
      MUL_PURF_COEF: begin
        mul_a = MUL_A_W'(pursuit_in) - MUL_A_W'(pursuit_filtered);
        mul_b = $signed({{(MUL_B_W-COEF_W){1'b0}}, coef_head_sat});
      end
      MUL_HEAD_DEG: begin
        mul_a = MUL_A_W'(head_in);
        mul_b = MUL_B_W'(DEG2RAD_Q32);
      end
      MUL_GA_LAT: begin
        mul_a = MUL_A_W'(lat_in);
        mul_b = gain_a;
      end
      MUL_GB_HR: begin
        mul_a = head_rad;
        mul_b = gain_b;
      end
      MUL_GC_PREV: begin
        mul_a = MUL_A_W'(prev_in);
        mul_b = gain_c;
      end
      MUL_GB_LATF: begin
        mul_a = MUL_A_W'(lat_filtered);
        mul_b = gain_b;
      end
      default: begin
        mul_a = MUL_A_W'(pursuit_filtered);
        mul_b = gain_a;
      end
    endcase
  end

  // products shift down with rounding toward minus infinity
  assign prod_frac   = ACC_W'(prod >>> FRAC_BITS);
  assign prod_coef   = FLT_W'(prod >>> COEF_BITS);
  assign flt_lat_sum = SUM_W'(lat_filtered) + SUM_W'(prod_coef);
  assign flt_pur_sum = SUM_W'(pursuit_filtered) + SUM_W'(prod_coef);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lat_in     <= lateral_error;
      head_in    <= heading_error;
      pursuit_in <= pursuit_angle;
      prev_in    <= previous_command;
    end
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (cmd.acc_op)
      ACC_HR:       head_rad <= MUL_A_W'(prod >>> DEG_SHIFT);
      ACC_LOAD:     acc      <= prod_frac;
      ACC_ADD:      acc      <= acc + prod_frac;
      ACC_ADD_HR:   acc      <= acc + ACC_W'(head_rad);
      ACC_ADD_PREV: acc      <= acc + ACC_W'(prev_in);
      default: ;
    endcase
    if (cmd.calc_target) begin
      target <= sat32(64'(delta_signed));
    end
    if (cmd.calc_diff) begin
      diff <= DATA_W'(raw_diff);
    end
    if (cmd.commit) begin
      target_angle <= target;
      steer_angle  <= steer_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_filtered     <= '0;
      pursuit_filtered <= '0;
      steer_current    <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cmd.acc_op == ACC_UPD_LATF) begin
        lat_filtered <= sat32(64'(flt_lat_sum));
      end
      if (cmd.acc_op == ACC_UPD_PURF) begin
        pursuit_filtered <= sat32(64'(flt_pur_sum));
      end
      if (cmd.commit) begin
        steer_current <= steer_new;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sliding mode keeps only the sign of the surface
  always_comb begin
    if (status.law == LAW_SMC) begin
      if (acc > 0) begin
        delta = -ACC_W'(gain_b);
      end else if (acc < 0) begin
        delta = ACC_W'(gain_b);
      end else begin
        delta = '0;
      end
    end else begin
      delta = acc;
    end
  end

  assign negate       = (status.law == LAW_LQR) ^ mode[2];
  assign delta_signed = negate ? -delta : delta;

  always_comb begin
    step_lim  = $signed({2'b00, max_step});
    angle_lim = $signed({2'b00, max_angle});
    raw_diff  = LIM_W'(target) - LIM_W'(steer_current);
    if (raw_diff > step_lim) begin
      raw_diff = step_lim;
    end else if (raw_diff < -step_lim) begin
      raw_diff = -step_lim;
    end
    raw_steer = LIM_W'(steer_current) + LIM_W'(diff);
    if (raw_steer > angle_lim) begin
      raw_steer = angle_lim;
    end else if (raw_steer < -angle_lim) begin
      raw_steer = -angle_lim;
    end
    steer_new = DATA_W'(raw_steer);
  end

endmodule

### rtl/steering_controller_rate_limited.sv
// ----------------------------------------------------------------------------
// steering_controller_rate_limited
// Lateral steering controller with per-tick rate limit and angle clamp.
// ----------------------------------------------------------------------------
// One input transfer is one control tick. The block takes lateral error,
// heading error, pursuit angle and previous command (all signed Q16.16),
// forms a target steer with the law selected by mode[1:0] (pure pursuit on
// low-pass filtered inputs, LQR, sliding mode or incremental MPC), inverts it
// when mode[2] is set, saturates it to 32 bits, limits the change against the
// current steer by max_step and clamps the result to +/-max_angle. Every
// multiply goes through one shared 33x32-bit multiplier, one product per
// cycle, so a tick takes an accept step, the law's multiply/accumulate steps
// (5 for pure pursuit, 4 for LQR and sliding mode, 6 for MPC) and the
// target, limit and commit steps. The input is stalled while a tick is in
// progress; a finished result sits in the output register and the next tick
// is taken while it waits, and only the commit of a later result waits for
// that register to drain. Configuration is written through a plain write
// port and must only change while the block is idle. Filter state and
// current steer clear on reset.
module steering_controller_rate_limited
  import scrl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] lateral_error,
  input  logic signed [DATA_W-1:0] heading_error,
  input  logic signed [DATA_W-1:0] pursuit_angle,
  input  logic signed [DATA_W-1:0] previous_command,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] target_angle,
  output logic signed [DATA_W-1:0] steer_angle
);

  cmd_t    cmd;
  status_t status;
  logic    busy;

  // hold off transfers during reset and while a tick is in progress
  assign in_stall = rst || busy;

  scrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  scrl_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .lateral_error    (lateral_error),
    .heading_error    (heading_error),
    .pursuit_angle    (pursuit_angle),
    .previous_command (previous_command),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .target_angle     (target_angle),
    .steer_angle      (steer_angle)
  );

endmodule

### rtl/scrl_checker.sv
// ----------------------------------------------------------------------------
// scrl_checker
// Port-level checks for the steering controller, bound to the top level.
// ----------------------------------------------------------------------------
module scrl_checker
  import scrl_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] target_angle,
  input logic signed [DATA_W-1:0] steer_angle
);

  // the input stays stalled right after a transfer is taken, over the start of a tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again too soon after a transfer");

  // a new result only appears out of a tick in progress
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a tick in progress");

  // first edge out of reset: nothing may be offered yet
  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target_angle) && $stable(steer_angle))
    else $error("stalled result changed");

endmodule

bind steering_controller_rate_limited scrl_checker u_scrl_checker (.*);
